// ----- src/i2crm_pkg.sv -----
// Package with the shared types, constants and phase codes of the I2C register master.
`timescale 1ns / 1ps

package i2crm_pkg;

  // Widths fixed by the request and result fields.
  localparam int unsigned ADDR_W     = 7;
  localparam int unsigned STRETCH_W  = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Default burst length limit for a read.
  localparam int unsigned MAX_READ_DEFAULT = 16;

  // Register values after reset.
  localparam logic [ADDR_W-1:0]    DEVICE_ADDRESS_RESET = 7'd104;
  localparam logic [STRETCH_W-1:0] STRETCH_LIMIT_RESET  = 16'd1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT  = 1'd1;

  // Sequencer phases.
  localparam int unsigned PHASE_W = 4;
  localparam logic [PHASE_W-1:0] P_IDLE   = 4'd0;
  localparam logic [PHASE_W-1:0] P_STA_HI = 4'd1;
  localparam logic [PHASE_W-1:0] P_STA_LO = 4'd2;
  localparam logic [PHASE_W-1:0] P_WLOW   = 4'd3;
  localparam logic [PHASE_W-1:0] P_WHIGH  = 4'd4;
  localparam logic [PHASE_W-1:0] P_ALOW   = 4'd5;
  localparam logic [PHASE_W-1:0] P_AHIGH  = 4'd6;
  localparam logic [PHASE_W-1:0] P_RSTART = 4'd7;
  localparam logic [PHASE_W-1:0] P_RLOW   = 4'd8;
  localparam logic [PHASE_W-1:0] P_RHIGH  = 4'd9;
  localparam logic [PHASE_W-1:0] P_MLOW   = 4'd10;
  localparam logic [PHASE_W-1:0] P_MHIGH  = 4'd11;
  localparam logic [PHASE_W-1:0] P_STO_A  = 4'd12;
  localparam logic [PHASE_W-1:0] P_STO_B  = 4'd13;
  localparam logic [PHASE_W-1:0] P_STO_C  = 4'd14;

  // Byte stages of a transaction.
  localparam logic [1:0] STAGE_ADDR_W = 2'd0;
  localparam logic [1:0] STAGE_REG    = 2'd1;
  localparam logic [1:0] STAGE_VALUE  = 2'd2;
  localparam logic [1:0] STAGE_ADDR_R = 2'd3;

  localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;
  localparam logic [3:0]        BITS_PER_BYTE = 4'd8;

  // Request kinds.
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase;
    logic [3:0]           bit_index;
    logic [BYTE_W-1:0]    shift_byte;
    logic [COUNT_W-1:0]   bytes_left;
    logic                 cmd_read;
    logic [BYTE_W-1:0]    cmd_reg;
    logic [BYTE_W-1:0]    cmd_value;
    logic [STRETCH_W-1:0] stretch_count;
    logic                 scl_low;
    logic                 sda_low;
    logic [1:0]           stage;
    logic                 fail_flag;
  } seq_state_t;

  typedef struct packed {
    logic              scl_drive_low;
    logic              sda_drive_low;
    logic              busy_res;
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic              read_last;
    logic              done_res;
    logic              failed;
  } result_t;

endpackage

// ----- src/i2crm_if.sv -----
// Handshake channel interfaces for requests, results and configuration writes.
`timescale 1ns / 1ps

interface i2crm_req_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic                            is_read;
  logic [i2crm_pkg::BYTE_W-1:0]    reg_address;
  logic [i2crm_pkg::BYTE_W-1:0]    write_value;
  logic [i2crm_pkg::COUNT_W-1:0]   read_count;
  logic                            sda_in;
  logic                            scl_in;

  modport source (output valid, kind, is_read, reg_address, write_value, read_count,
                  sda_in, scl_in, input ready);
  modport sink (input valid, kind, is_read, reg_address, write_value, read_count,
                sda_in, scl_in, output ready);
endinterface

interface i2crm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         scl_drive_low;
  logic                         sda_drive_low;
  logic                         busy_res;
  logic                         read_valid;
  logic [i2crm_pkg::BYTE_W-1:0] read_byte;
  logic                         read_last;
  logic                         done_res;
  logic                         failed;

  modport source (output valid, scl_drive_low, sda_drive_low, busy_res, read_valid,
                  read_byte, read_last, done_res, failed, input ready);
  modport sink (input valid, scl_drive_low, sda_drive_low, busy_res, read_valid,
                read_byte, read_last, done_res, failed, output ready);
endinterface

interface i2crm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [i2crm_pkg::CFG_IDX_W-1:0]  index;
  logic [i2crm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/i2crm_step.sv -----
// Next-state logic of the I2C bit sequencer for one tick or command request.
`timescale 1ns / 1ps

module i2crm_step #(
  parameter int unsigned MAX_READ = i2crm_pkg::MAX_READ_DEFAULT
) (
  input  i2crm_pkg::seq_state_t                 st,
  input  logic                                  kind,
  input  logic                                  is_read,
  input  logic [i2crm_pkg::BYTE_W-1:0]          reg_address,
  input  logic [i2crm_pkg::BYTE_W-1:0]          write_value,
  input  logic [i2crm_pkg::COUNT_W-1:0]         read_count,
  input  logic                                  sda_in,
  input  logic                                  scl_in,
  input  logic [i2crm_pkg::ADDR_W-1:0]          device_address,
  input  logic [i2crm_pkg::STRETCH_W-1:0]       stretch_limit,
  output i2crm_pkg::seq_state_t                 st_next,
  output i2crm_pkg::result_t                    res
);

  logic                          high_phase;
  logic [i2crm_pkg::COUNT_W-1:0] count_clamped;
  logic [i2crm_pkg::BYTE_W-1:0]  addr_byte;
  logic [i2crm_pkg::BYTE_W-1:0]  send_byte;
  logic                          start_send;
  logic [3:0]                    bit_next;
  logic [i2crm_pkg::BYTE_W-1:0]  shifted;
  logic [i2crm_pkg::BYTE_W-1:0]  sampled;
  logic [i2crm_pkg::COUNT_W-1:0] left_next;

  assign addr_byte = {device_address, 1'b0};
  assign bit_next  = st.bit_index + 4'd1;
  assign shifted   = {st.shift_byte[i2crm_pkg::BYTE_W-2:0], 1'b0};
  assign sampled   = {st.shift_byte[i2crm_pkg::BYTE_W-2:0], sda_in};
  assign left_next = (st.bytes_left != '0) ? st.bytes_left - 1'b1 : st.bytes_left;

  always_comb begin
    count_clamped = read_count;
    if (count_clamped == '0) begin
      count_clamped = i2crm_pkg::COUNT_W'(1);
    end
    if (32'(count_clamped) > MAX_READ) begin
      count_clamped = i2crm_pkg::COUNT_W'(MAX_READ);
    end
  end

  assign high_phase = (st.phase == i2crm_pkg::P_STA_HI) || (st.phase == i2crm_pkg::P_WHIGH) ||
                      (st.phase == i2crm_pkg::P_AHIGH)  || (st.phase == i2crm_pkg::P_RHIGH) ||
                      (st.phase == i2crm_pkg::P_MHIGH)  || (st.phase == i2crm_pkg::P_STO_B);

  always_comb begin
    st_next    = st;
    res        = '0;
    start_send = 1'b0;
    send_byte  = '0;

    if (kind == i2crm_pkg::KIND_COMMAND) begin
      if (st.phase == i2crm_pkg::P_IDLE) begin
        st_next.cmd_read      = is_read;
        st_next.cmd_reg       = reg_address;
        st_next.cmd_value     = write_value;
        st_next.bytes_left    = count_clamped;
        st_next.stage         = i2crm_pkg::STAGE_ADDR_W;
        st_next.fail_flag     = 1'b0;
        st_next.stretch_count = '0;
        st_next.bit_index     = '0;
        st_next.shift_byte    = '0;
        st_next.scl_low       = 1'b0;
        st_next.sda_low       = 1'b0;
        st_next.phase         = i2crm_pkg::P_STA_HI;
      end
    end else if (high_phase && !scl_in && (st.stretch_count < stretch_limit)) begin
      // The target holds SCL low: wait, counting ticks up to the limit.
      st_next.stretch_count = st.stretch_count + 1'b1;
    end else begin
      if (high_phase) begin
        st_next.stretch_count = '0;
      end
      unique case (st.phase)
        i2crm_pkg::P_STA_HI: begin
          st_next.scl_low = 1'b0;
          st_next.sda_low = 1'b1;
          st_next.phase   = i2crm_pkg::P_STA_LO;
        end
        i2crm_pkg::P_STA_LO: begin
          start_send = 1'b1;
          send_byte  = (st.stage == i2crm_pkg::STAGE_ADDR_R) ? (addr_byte | 8'h01) : addr_byte;
        end
        i2crm_pkg::P_WLOW: begin
          st_next.scl_low = 1'b0;
          st_next.phase   = i2crm_pkg::P_WHIGH;
        end
        i2crm_pkg::P_WHIGH: begin
          st_next.bit_index = bit_next;
          if (bit_next < i2crm_pkg::BITS_PER_BYTE) begin
            st_next.shift_byte = shifted;
            st_next.scl_low    = 1'b1;
            st_next.sda_low    = (shifted & i2crm_pkg::MSB_MASK) == '0;
            st_next.phase      = i2crm_pkg::P_WLOW;
          end else begin
            st_next.scl_low = 1'b1;
            st_next.sda_low = 1'b0;
            st_next.phase   = i2crm_pkg::P_ALOW;
          end
        end
        i2crm_pkg::P_ALOW: begin
          st_next.scl_low = 1'b0;
          st_next.sda_low = 1'b0;
          st_next.phase   = i2crm_pkg::P_AHIGH;
        end
        i2crm_pkg::P_AHIGH: begin
          if (sda_in) begin
            // Not acknowledged: go straight to stop and report failure.
            st_next.fail_flag = 1'b1;
            st_next.scl_low   = 1'b1;
            st_next.sda_low   = 1'b1;
            st_next.phase     = i2crm_pkg::P_STO_A;
          end else begin
            unique case (st.stage)
              i2crm_pkg::STAGE_ADDR_W: begin
                st_next.stage = i2crm_pkg::STAGE_REG;
                start_send    = 1'b1;
                send_byte     = st.cmd_reg;
              end
              i2crm_pkg::STAGE_REG: begin
                if (st.cmd_read) begin
                  st_next.stage   = i2crm_pkg::STAGE_ADDR_R;
                  st_next.scl_low = 1'b1;
                  st_next.sda_low = 1'b0;
                  st_next.phase   = i2crm_pkg::P_RSTART;
                end else begin
                  st_next.stage = i2crm_pkg::STAGE_VALUE;
                  start_send    = 1'b1;
                  send_byte     = st.cmd_value;
                end
              end
              i2crm_pkg::STAGE_VALUE: begin
                st_next.scl_low = 1'b1;
                st_next.sda_low = 1'b1;
                st_next.phase   = i2crm_pkg::P_STO_A;
              end
              default: begin
                st_next.shift_byte = '0;
                st_next.bit_index  = '0;
                st_next.scl_low    = 1'b1;
                st_next.sda_low    = 1'b0;
                st_next.phase      = i2crm_pkg::P_RLOW;
              end
            endcase
          end
        end
        i2crm_pkg::P_RSTART: begin
          st_next.scl_low = 1'b0;
          st_next.sda_low = 1'b0;
          st_next.phase   = i2crm_pkg::P_STA_HI;
        end
        i2crm_pkg::P_RLOW: begin
          st_next.scl_low = 1'b0;
          st_next.sda_low = 1'b0;
          st_next.phase   = i2crm_pkg::P_RHIGH;
        end
        i2crm_pkg::P_RHIGH: begin
          st_next.shift_byte = sampled;
          st_next.bit_index  = bit_next;
          if (bit_next < i2crm_pkg::BITS_PER_BYTE) begin
            st_next.scl_low = 1'b1;
            st_next.sda_low = 1'b0;
            st_next.phase   = i2crm_pkg::P_RLOW;
          end else begin
            // Byte complete: ACK unless it is the last of the burst.
            st_next.bytes_left = left_next;
            res.read_valid     = 1'b1;
            res.read_byte      = sampled;
            res.read_last      = left_next == '0;
            st_next.scl_low    = 1'b1;
            st_next.sda_low    = left_next != '0;
            st_next.phase      = i2crm_pkg::P_MLOW;
          end
        end
        i2crm_pkg::P_MLOW: begin
          st_next.scl_low = 1'b0;
          st_next.phase   = i2crm_pkg::P_MHIGH;
        end
        i2crm_pkg::P_MHIGH: begin
          if (st.bytes_left != '0) begin
            st_next.shift_byte = '0;
            st_next.bit_index  = '0;
            st_next.scl_low    = 1'b1;
            st_next.sda_low    = 1'b0;
            st_next.phase      = i2crm_pkg::P_RLOW;
          end else begin
            st_next.scl_low = 1'b1;
            st_next.sda_low = 1'b1;
            st_next.phase   = i2crm_pkg::P_STO_A;
          end
        end
        i2crm_pkg::P_STO_A: begin
          st_next.scl_low = 1'b0;
          st_next.sda_low = 1'b1;
          st_next.phase   = i2crm_pkg::P_STO_B;
        end
        i2crm_pkg::P_STO_B: begin
          st_next.scl_low = 1'b0;
          st_next.sda_low = 1'b0;
          st_next.phase   = i2crm_pkg::P_STO_C;
        end
        i2crm_pkg::P_STO_C: begin
          res.done_res      = 1'b1;
          res.failed        = st.fail_flag;
          st_next.fail_flag = 1'b0;
          st_next.phase     = i2crm_pkg::P_IDLE;
        end
        default: begin
          st_next.scl_low = 1'b0;
          st_next.sda_low = 1'b0;
          st_next.phase   = i2crm_pkg::P_IDLE;
        end
      endcase

      if (start_send) begin
        st_next.shift_byte = send_byte;
        st_next.bit_index  = '0;
        st_next.scl_low    = 1'b1;
        st_next.sda_low    = (send_byte & i2crm_pkg::MSB_MASK) == '0;
        st_next.phase      = i2crm_pkg::P_WLOW;
      end
    end

    res.scl_drive_low = st_next.scl_low;
    res.sda_drive_low = st_next.sda_low;
    res.busy_res      = st_next.phase != i2crm_pkg::P_IDLE;
  end

endmodule

// ----- src/i2c_register_master.sv -----
// Top level of the I2C register master: request and result channels, registers, state.
`timescale 1ns / 1ps

// The I2C register master runs single-register writes and burst reads on an
// open-drain bus. Every request on the req channel is either a half-bit tick
// carrying the sampled SDA and SCL levels, or a new command; a command that
// arrives while a transaction is running is treated as a tick that changes
// nothing. Every accepted request produces exactly one result on the rsp
// channel with the new line drives, the busy flag, any received byte and the
// done and failure flags.
// The sequencer state and the result are both registered at the edge that
// accepts a request, so the result sits in the output register in the cycle
// after; while results are taken, a new request is taken every cycle. The only
// path from request to result is the next-state logic of the bit sequencer.
// When the receiver stalls, the output register holds its result and req
// ready drops until the result is taken; ready is high again in the same
// cycle the result leaves.
// The cfg channel writes the device address and the clock stretch limit; it
// is always ready and is meant to be used while the block is idle.
// Synchronous reset returns the sequencer to idle with both lines released,
// empties the output register and loads the register defaults.
module i2c_register_master #(
  parameter int unsigned MAX_READ = i2crm_pkg::MAX_READ_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  i2crm_req_if.sink    req,
  i2crm_rsp_if.source  rsp,
  i2crm_cfg_if.sink    cfg
);

  i2crm_pkg::seq_state_t st;
  i2crm_pkg::seq_state_t st_next;
  i2crm_pkg::result_t    res_next;
  i2crm_pkg::result_t    res;

  logic [i2crm_pkg::ADDR_W-1:0]    device_address;
  logic [i2crm_pkg::STRETCH_W-1:0] stretch_limit;
  logic                            out_valid;
  logic                            req_take;

  // The output register frees up when it is empty or being read this cycle.
  assign req.ready = !out_valid || rsp.ready;
  assign req_take  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  i2crm_step #(
    .MAX_READ (MAX_READ)
  ) u_step (
    .st             (st),
    .kind           (req.kind),
    .is_read        (req.is_read),
    .reg_address    (req.reg_address),
    .write_value    (req.write_value),
    .read_count     (req.read_count),
    .sda_in         (req.sda_in),
    .scl_in         (req.scl_in),
    .device_address (device_address),
    .stretch_limit  (stretch_limit),
    .st_next        (st_next),
    .res            (res_next)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2crm_pkg::DEVICE_ADDRESS_RESET;
      stretch_limit  <= i2crm_pkg::STRETCH_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        i2crm_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg.data[i2crm_pkg::ADDR_W-1:0];
        i2crm_pkg::CFG_STRETCH_LIMIT:  stretch_limit  <= cfg.data[i2crm_pkg::STRETCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state advances once per accepted request. The all-zero state
  // is idle with both lines released.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (req_take) begin
      st <= st_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      res <= res_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.scl_drive_low = res.scl_drive_low;
  assign rsp.sda_drive_low = res.sda_drive_low;
  assign rsp.busy_res      = res.busy_res;
  assign rsp.read_valid    = res.read_valid;
  assign rsp.read_byte     = res.read_byte;
  assign rsp.read_last     = res.read_last;
  assign rsp.done_res      = res.done_res;
  assign rsp.failed        = res.failed;

endmodule
